// ===== src/tcld_pkg.sv =====
// Package for the text command line decoder.
// Types, constants and helper functions shared by the controller, datapath and top level.
// No dependencies.
package tcld_pkg;

    localparam int LINE_LEN_DEF   = 64;
    localparam int MAX_TOKENS_DEF = 8;

    localparam logic [1:0] ECHO_NONE = 2'd0;
    localparam logic [1:0] ECHO_CHAR = 2'd1;
    localparam logic [1:0] ECHO_EOL  = 2'd2;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_DRIVE = 2'd2;
    localparam logic [1:0] ACT_OMEGA = 2'd3;

    localparam logic [1:0] DRV_STOP = 2'd0;
    localparam logic [1:0] DRV_FWD  = 2'd1;
    localparam logic [1:0] DRV_REV  = 2'd2;

    localparam logic [20:0] HOLD_LONG  = 21'd2000000;
    localparam logic [20:0] HOLD_SHORT = 21'd500000;

    localparam logic [7:0] CHR_BS = 8'd8;
    localparam logic [7:0] CHR_CR = 8'd13;

    // Keyword codes for the token matcher
    typedef enum logic [3:0] {
        KW_START, KW_ROBOT, KW_FORWARD, KW_BACKWARD, KW_RIGHT,
        KW_LEFT, KW_STOP, KW_WIGGLE, KW_SET, KW_OMEGA, KW_COUNT
    } kw_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECODE, ST_EMIT, ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic store_char;
        logic back_space;
        logic scan_clear;
        logic scan_step;
        logic decode;
        logic load_out;
        logic [1:0] out_step;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic [2:0] n_results;
    } dp_stat_t;

    function automatic logic [7:0] kw_char(input kw_t kw, input logic [2:0] k);
        logic [63:0] s;
        case (kw)
            KW_START:    s = {"START", 24'd0};
            KW_ROBOT:    s = {"ROBOT", 24'd0};
            KW_FORWARD:  s = {"FORWARD", 8'd0};
            KW_BACKWARD: s = "BACKWARD";
            KW_RIGHT:    s = {"RIGHT", 24'd0};
            KW_LEFT:     s = {"LEFT", 32'd0};
            KW_STOP:     s = {"STOP", 32'd0};
            KW_WIGGLE:   s = {"WIGGLE", 16'd0};
            KW_SET:      s = {"SET", 40'd0};
            KW_OMEGA:    s = {"OMEGA", 24'd0};
            default:     s = 64'd0;
        endcase
        return s[63 - 8 * k -: 8];
    endfunction

    function automatic logic [3:0] kw_len(input kw_t kw);
        case (kw)
            KW_START, KW_ROBOT, KW_RIGHT, KW_OMEGA: return 4'd5;
            KW_FORWARD:  return 4'd7;
            KW_BACKWARD: return 4'd8;
            KW_LEFT, KW_STOP: return 4'd4;
            KW_WIGGLE:   return 4'd6;
            KW_SET:      return 4'd3;
            default:     return 4'd0;
        endcase
    endfunction

    function automatic logic tok_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
               c == "." || c == "-" || c == "&";
    endfunction

endpackage

// ===== src/text_command_line_decoder_core.sv =====
// Top level of the text command line decoder.
// Instantiates tcld_ctrl and tcld_datapath; depends on tcld_pkg.
//
// Bytes are taken one at a time on s_rx_byte. An ordinary byte gives one
// result in the cycle after it is taken. A carriage return walks the stored
// line one byte per cycle through the line buffer read port; the first
// result follows after ST_DECODE and ST_EMIT. A WIGGLE line then gives four
// results, each held until taken, the next one loaded in ST_EMIT after each
// taken result. No new byte is taken until the last result of the previous
// one has gone out; the input is ready again in the cycle after that.
module text_command_line_decoder_core #(
    parameter int LINE_LEN   = tcld_pkg::LINE_LEN_DEF,
    parameter int MAX_TOKENS = tcld_pkg::MAX_TOKENS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_echo_kind,
    output logic [7:0]         m_echo_char,
    output logic               m_overflow,
    output logic [1:0]         m_action,
    output logic [1:0]         m_left_drive,
    output logic [1:0]         m_right_drive,
    output logic [20:0]        m_hold_us,
    output logic [1:0]         m_omega_device,
    output logic signed [31:0] m_omega_value,
    output logic               m_started_flag,
    output logic               m_last
);

    tcld_pkg::dp_cmd_t  cmd;
    tcld_pkg::dp_stat_t stat;

    tcld_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_byte(s_rx_byte), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready), .out_last(m_last),
        .stat(stat), .cmd(cmd)
    );

    tcld_datapath #(.LINE_LEN(LINE_LEN), .MAX_TOKENS(MAX_TOKENS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_byte(s_rx_byte),
        .cmd(cmd), .stat(stat),
        .echo_kind(m_echo_kind), .echo_char(m_echo_char), .overflow(m_overflow),
        .action(m_action), .left_drive(m_left_drive), .right_drive(m_right_drive),
        .hold_us(m_hold_us), .omega_device(m_omega_device),
        .omega_value(m_omega_value), .started_flag(m_started_flag)
    );

endmodule

// ===== src/tcld_ctrl.sv =====
// Controller state machine of the text command line decoder.
// Depends on tcld_pkg.
module tcld_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_last,
    input  tcld_pkg::dp_stat_t  stat,
    output tcld_pkg::dp_cmd_t   cmd
);

    tcld_pkg::state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;

    logic acc;
    logic is_print;
    logic out_done;
    assign acc      = in_valid && in_ready;
    assign is_print = (in_byte >= 8'h20 && in_byte <= 8'h5A) ||
                      (in_byte >= 8'h61 && in_byte <= 8'h7A);
    assign out_last = ({1'b0, step_reg} + 3'd1) >= stat.n_results;
    assign out_done = out_valid && out_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            tcld_pkg::ST_IDLE: begin
                if (acc) begin
                    step_next = 2'd0;
                    if (in_byte == tcld_pkg::CHR_CR) state_next = tcld_pkg::ST_SCAN;
                    else state_next = tcld_pkg::ST_OUT;
                end
            end
            tcld_pkg::ST_SCAN: begin
                if (stat.scan_done) state_next = tcld_pkg::ST_DECODE;
            end
            tcld_pkg::ST_DECODE: state_next = tcld_pkg::ST_EMIT;
            tcld_pkg::ST_EMIT:   state_next = tcld_pkg::ST_OUT;
            tcld_pkg::ST_OUT: begin
                if (out_done) begin
                    if (out_last) state_next = tcld_pkg::ST_IDLE;
                    else begin
                        step_next  = step_reg + 2'd1;
                        state_next = tcld_pkg::ST_EMIT;
                    end
                end
            end
            default: state_next = tcld_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        in_ready = 1'b0;
        out_valid = 1'b0;
        cmd = '0;
        cmd.out_step = step_reg;
        unique case (state_reg)
            tcld_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.store_char = acc && is_print;
                cmd.back_space = acc && in_byte == tcld_pkg::CHR_BS;
                cmd.scan_clear = acc;
                cmd.load_out   = acc && in_byte != tcld_pkg::CHR_CR;
            end
            tcld_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
            tcld_pkg::ST_DECODE: cmd.decode = 1'b1;
            tcld_pkg::ST_EMIT:   cmd.load_out = 1'b1;
            tcld_pkg::ST_OUT:    out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcld_pkg::ST_IDLE;
            step_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== src/tcld_datapath.sv =====
// Datapath of the text command line decoder: line buffer, token scanner,
// keyword matchers, value decoder and result register. Depends on tcld_pkg.
module tcld_datapath #(
    parameter int LINE_LEN   = tcld_pkg::LINE_LEN_DEF,
    parameter int MAX_TOKENS = tcld_pkg::MAX_TOKENS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         in_byte,
    input  tcld_pkg::dp_cmd_t  cmd,
    output tcld_pkg::dp_stat_t stat,
    output logic [1:0]         echo_kind,
    output logic [7:0]         echo_char,
    output logic               overflow,
    output logic [1:0]         action,
    output logic [1:0]         left_drive,
    output logic [1:0]         right_drive,
    output logic [20:0]        hold_us,
    output logic [1:0]         omega_device,
    output logic signed [31:0] omega_value,
    output logic               started_flag
);

    localparam int AW = $clog2(LINE_LEN);
    localparam int WW = $clog2(LINE_LEN + 1);
    localparam int TW = $clog2(MAX_TOKENS + 1);
    localparam int NK = 10;

    logic [7:0] line_mem [LINE_LEN];
    logic [WW-1:0] widx_reg;
    logic started_reg;
    logic [31:0] omega_reg [3];

    logic [7:0] up_byte;
    assign up_byte = (in_byte >= 8'h61) ? in_byte - 8'd32 : in_byte;
    logic full;
    assign full = widx_reg >= WW'(LINE_LEN - 2);

    // Line buffer and write index
    always_ff @(posedge aclk) begin
        if (cmd.store_char && !full) line_mem[widx_reg[AW-1:0]] <= up_byte;
    end

    // Scan pipeline: read one byte per cycle
    logic [WW-1:0] len_reg;
    logic [WW-1:0] rpos_reg;
    logic          rd_v_reg;
    logic [WW-1:0] dpos_reg;
    logic [7:0]    rd_reg;
    always_ff @(posedge aclk) begin
        rd_reg <= line_mem[rpos_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg <= '0;
        end else if (cmd.store_char && !full) begin
            widx_reg <= widx_reg + 1'b1;
        end else if (cmd.back_space && widx_reg != '0) begin
            widx_reg <= widx_reg - 1'b1;
        end else if (cmd.scan_clear && in_byte == tcld_pkg::CHR_CR) begin
            widx_reg <= '0;
        end
    end

    // Per-token state
    logic [TW-1:0] count_reg;
    logic          prev_delim_reg;
    logic [3:0]    tpos_reg;        // char position inside current token (saturating)
    logic          tlong_reg;       // current token longer than 15
    logic [NK-1:0] m0_reg, m1_reg;  // keyword matches for token 0 and 1
    logic [NK-1:0] mcur_reg;
    logic [7:0]    dev_ch_reg;
    logic          neg_reg, vdig_reg;
    logic [31:0]   mag_reg;         // saturates at 2^31
    logic [TW-1:0] tok_idx_prev_reg;

    logic cur_delim, new_tok, in_tok;
    logic [TW-1:0] tok_idx;
    assign cur_delim = (dpos_reg != '0) && !tcld_pkg::tok_char(rd_reg);
    assign new_tok   = !cur_delim && dpos_reg >= WW'(2) && prev_delim_reg &&
                       count_reg < TW'(MAX_TOKENS);
    assign in_tok    = !cur_delim && (dpos_reg == '0 || new_tok || !prev_delim_reg);
    assign tok_idx   = (dpos_reg == '0) ? '0 : (new_tok ? count_reg : count_reg - 1'b1);

    logic [3:0] kpos;
    assign kpos = (dpos_reg == '0 || new_tok) ? 4'd0 : tpos_reg;
    logic klong;
    assign klong = (dpos_reg == '0 || new_tok) ? 1'b0 : tlong_reg;

    logic [NK-1:0] mnext;
    logic [NK-1:0] mfin;
    always_comb begin
        for (int k = 0; k < NK; k++) begin
            mnext[k] = ((kpos == 4'd0) ? 1'b1 : mcur_reg[k]) && !klong &&
                kpos < tcld_pkg::kw_len(tcld_pkg::kw_t'(k)) &&
                tcld_pkg::kw_char(tcld_pkg::kw_t'(k), kpos[2:0]) == rd_reg;
            mfin[k] = mcur_reg[k] && !tlong_reg &&
                tpos_reg == tcld_pkg::kw_len(tcld_pkg::kw_t'(k));
        end
    end

    // Value digit step
    logic        is_dig;
    logic [35:0] mag_mul;
    assign is_dig  = rd_reg >= "0" && rd_reg <= "9";
    assign mag_mul = {4'd0, mag_reg} * 36'd10 + {32'd0, rd_reg[3:0]};

    logic tok_open;  // a recorded token is open and being tracked
    logic tok_open_reg;
    assign tok_open = in_tok && (dpos_reg == '0 || new_tok || tok_open_reg);

    logic last_rd;
    assign last_rd = rd_v_reg && (dpos_reg + 1'b1 == len_reg);
    assign stat.scan_done = (len_reg == '0) || last_rd;

    always_ff @(posedge aclk) begin
        if (cmd.scan_clear) begin
            len_reg   <= (widx_reg > WW'(LINE_LEN)) ? WW'(LINE_LEN) : widx_reg;
            rpos_reg  <= '0;
            rd_v_reg  <= 1'b0;
            count_reg <= '0;
            m0_reg <= '0;
            m1_reg <= '0;
            prev_delim_reg <= 1'b0;
            tok_open_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            rpos_reg <= rpos_reg + 1'b1;
            dpos_reg <= rpos_reg;
            rd_v_reg <= (rpos_reg < len_reg);
            if (rd_v_reg) begin
                prev_delim_reg <= cur_delim;
                tok_open_reg   <= tok_open;
                if (dpos_reg == '0) count_reg <= TW'(1);
                else if (new_tok) count_reg <= count_reg + 1'b1;
                if (tok_open) begin
                    mcur_reg <= mnext;
                    tpos_reg <= (kpos == 4'd15) ? 4'd15 : kpos + 4'd1;
                    tlong_reg <= klong || kpos == 4'd15;
                    if (tok_idx == TW'(0)) m0_reg <= mnext;
                    if (tok_idx == TW'(1)) m1_reg <= mnext;
                    if (tok_idx == TW'(3) && kpos == 4'd0) dev_ch_reg <= rd_reg;
                    if (tok_idx == TW'(2)) begin
                        if (kpos == 4'd0) begin
                            neg_reg  <= rd_reg == "-";
                            vdig_reg <= is_dig;
                            mag_reg  <= is_dig ? {28'd0, rd_reg[3:0]} : 32'd0;
                        end else if (vdig_reg || (kpos == 4'd1 && neg_reg)) begin
                            // digits run on after an optional leading minus
                            if (is_dig) begin
                                vdig_reg <= 1'b1;
                                mag_reg <= (mag_mul > 36'h80000000) ? 32'h80000000
                                                                    : mag_mul[31:0];
                            end else begin
                                vdig_reg <= 1'b0;
                            end
                        end
                    end
                end
                // token 0/1 final match latched at its end
                if (!tok_open && tok_open_reg) begin
                    if (tok_idx_prev_reg == TW'(0)) m0_reg <= mfin;
                    if (tok_idx_prev_reg == TW'(1)) m1_reg <= mfin;
                end
            end
        end
    end

    // Remember which token is open for end-of-token latching
    always_ff @(posedge aclk) begin
        if (cmd.scan_step && rd_v_reg && tok_open) tok_idx_prev_reg <= tok_idx;
    end

    // Final matches: close an open token at line end
    logic [NK-1:0] f0, f1;
    logic [NK-1:0] mfin_end;
    always_comb begin
        for (int k = 0; k < NK; k++) begin
            mfin_end[k] = mcur_reg[k] && !tlong_reg &&
                tpos_reg == tcld_pkg::kw_len(tcld_pkg::kw_t'(k));
        end
        f0 = m0_reg;
        f1 = m1_reg;
        if (tok_open_reg && tok_idx_prev_reg == TW'(0)) f0 = mfin_end;
        if (tok_open_reg && tok_idx_prev_reg == TW'(1)) f1 = mfin_end;
    end

    // Decode into result plan
    logic [2:0]  nres_reg;
    logic [2:0]  nres_reg_eff;
    logic [1:0]  act_reg;
    logic [1:0]  dl_reg, dr_reg;
    logic [1:0]  devn_reg;
    logic [31:0] val_reg;
    logic        is_cr_reg;
    logic        wig_reg;
    logic [31:0] val_dec;
    assign val_dec = neg_reg ? (32'd0 - mag_reg)
                   : (mag_reg[31] ? 32'h7FFFFFFF : mag_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            for (int i = 0; i < 3; i++) omega_reg[i] <= 32'd100;
        end else if (cmd.decode) begin
            nres_reg <= 3'd1;
            act_reg  <= tcld_pkg::ACT_NONE;
            wig_reg  <= 1'b0;
            dl_reg <= tcld_pkg::DRV_STOP;
            dr_reg <= tcld_pkg::DRV_STOP;
            devn_reg <= 2'd0;
            val_reg <= 32'd0;
            if (len_reg == '0) begin
            end else if (count_reg == TW'(1)) begin
                if (f0[tcld_pkg::KW_START]) begin
                    started_reg <= 1'b1;
                    act_reg <= tcld_pkg::ACT_START;
                end
            end else if (count_reg == TW'(2)) begin
                if (f0[tcld_pkg::KW_ROBOT]) begin
                    act_reg <= tcld_pkg::ACT_DRIVE;
                    if (f1[tcld_pkg::KW_FORWARD]) begin
                        dl_reg <= tcld_pkg::DRV_FWD; dr_reg <= tcld_pkg::DRV_FWD;
                    end else if (f1[tcld_pkg::KW_BACKWARD]) begin
                        dl_reg <= tcld_pkg::DRV_REV; dr_reg <= tcld_pkg::DRV_REV;
                    end else if (f1[tcld_pkg::KW_RIGHT]) begin
                        dl_reg <= tcld_pkg::DRV_FWD; dr_reg <= tcld_pkg::DRV_REV;
                    end else if (f1[tcld_pkg::KW_LEFT]) begin
                        dl_reg <= tcld_pkg::DRV_REV; dr_reg <= tcld_pkg::DRV_FWD;
                    end else if (f1[tcld_pkg::KW_STOP]) begin
                    end else if (f1[tcld_pkg::KW_WIGGLE]) begin
                        wig_reg <= 1'b1;
                        nres_reg <= 3'd4;
                    end else begin
                        act_reg <= tcld_pkg::ACT_NONE;
                    end
                end
            end else if (count_reg == TW'(4)) begin
                if (f0[tcld_pkg::KW_SET] && f1[tcld_pkg::KW_OMEGA] &&
                    dev_ch_reg >= "1" && dev_ch_reg <= "3") begin
                    act_reg  <= tcld_pkg::ACT_OMEGA;
                    devn_reg <= dev_ch_reg[1:0];
                    val_reg  <= val_dec;
                    omega_reg[dev_ch_reg[1:0] - 2'd1] <= val_dec;
                end
            end
        end
    end
    assign nres_reg_eff = is_cr_reg ? nres_reg : 3'd1;
    assign stat.n_results = cmd.decode ? 3'd1 : nres_reg_eff;

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.scan_clear) is_cr_reg <= in_byte == tcld_pkg::CHR_CR;
        if (cmd.load_out) begin
            echo_kind <= tcld_pkg::ECHO_NONE;
            echo_char <= 8'd0;
            overflow  <= 1'b0;
            action    <= tcld_pkg::ACT_NONE;
            left_drive <= tcld_pkg::DRV_STOP;
            right_drive <= tcld_pkg::DRV_STOP;
            hold_us <= 21'd0;
            omega_device <= 2'd0;
            omega_value <= 32'sd0;
            // an ordinary byte loads at its accept; a line end loads from the plan
            if (cmd.scan_clear) begin
                if (cmd.store_char) begin
                    if (full) overflow <= 1'b1;
                    else begin
                        echo_kind <= tcld_pkg::ECHO_CHAR;
                        echo_char <= up_byte;
                    end
                end else if (cmd.back_space && widx_reg != '0) begin
                    echo_kind <= tcld_pkg::ECHO_CHAR;
                    echo_char <= tcld_pkg::CHR_BS;
                end
            end else begin
                if (cmd.out_step == 2'd0) echo_kind <= tcld_pkg::ECHO_EOL;
                if (wig_reg) begin
                    action <= tcld_pkg::ACT_DRIVE;
                    case (cmd.out_step)
                        2'd0: begin
                            left_drive <= tcld_pkg::DRV_REV; right_drive <= tcld_pkg::DRV_FWD;
                            hold_us <= tcld_pkg::HOLD_LONG;
                        end
                        2'd1: begin
                            left_drive <= tcld_pkg::DRV_FWD; right_drive <= tcld_pkg::DRV_REV;
                            hold_us <= tcld_pkg::HOLD_SHORT;
                        end
                        2'd2: begin
                            left_drive <= tcld_pkg::DRV_FWD; right_drive <= tcld_pkg::DRV_FWD;
                            hold_us <= tcld_pkg::HOLD_LONG;
                        end
                        default: ;
                    endcase
                end else begin
                    action <= act_reg;
                    left_drive <= dl_reg;
                    right_drive <= dr_reg;
                    omega_device <= devn_reg;
                    omega_value <= val_reg;
                end
            end
        end
    end
    assign started_flag = started_reg;

endmodule

// ===== verif/text_command_line_decoder_core_tb.sv =====
// Testbench for text_command_line_decoder_core: line editing and command decoding.
// Sends bytes through a randomly idled driver and checks each result against a
// built-in line decoder. Depends on tcld_pkg and the core RTL.
`timescale 1ns / 1ps

module text_command_line_decoder_core_tb;

    localparam int LINE_LEN   = tcld_pkg::LINE_LEN_DEF;
    localparam int MAX_TOKENS = tcld_pkg::MAX_TOKENS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 230;

    typedef struct packed {
        logic [1:0]         echo_kind;
        logic [7:0]         echo_char;
        logic               overflow;
        logic [1:0]         action;
        logic [1:0]         left_drive;
        logic [1:0]         right_drive;
        logic [20:0]        hold_us;
        logic [1:0]         omega_device;
        logic signed [31:0] omega_value;
        logic               started_flag;
        logic               last;
    } dec_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'd0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_echo_kind;
    logic [7:0]         m_echo_char;
    logic               m_overflow;
    logic [1:0]         m_action;
    logic [1:0]         m_left_drive;
    logic [1:0]         m_right_drive;
    logic [20:0]        m_hold_us;
    logic [1:0]         m_omega_device;
    logic signed [31:0] m_omega_value;
    logic               m_started_flag;
    logic               m_last;

    text_command_line_decoder_core u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor state
    logic [7:0]  line_mem [LINE_LEN];
    int          wr_idx;
    logic        started_q;
    logic [31:0] omega_mem [3];

    logic [7:0] pending_bytes [$];
    dec_res_t   expected_results [$];
    int  error_count = 0;
    int  cycle_count = 0;
    int  results_seen = 0;
    int  actions_seen = 0;
    int  overflows_seen = 0;
    int  queued_count = 0;
    bit  stim_done = 1'b0;

    function automatic bit is_delim(int pos);
        return pos >= 1 && !tcld_pkg::tok_char(line_mem[pos]);
    endfunction

    function automatic int token_length(int start, int len);
        int j;
        j = start;
        while (j < len && !is_delim(j)) j++;
        return j - start;
    endfunction

    function automatic bit token_matches(int start, int len, string word);
        int n;
        n = token_length(start, len);
        if (n != word.len()) return 0;
        for (int k = 0; k < n; k++)
            if (line_mem[start + k] != word[k]) return 0;
        return 1;
    endfunction

    // atoi-style decode, saturated to 32 bits signed
    function automatic logic [31:0] omega_from_token(int start, int len);
        int p, stop;
        bit neg;
        longint mag;
        p = start;
        stop = start + token_length(start, len);
        neg = 0;
        mag = 0;
        if (p < stop && line_mem[p] == "-") begin
            neg = 1;
            p++;
        end
        while (p < stop && line_mem[p] >= "0" && line_mem[p] <= "9") begin
            mag = mag * 10 + longint'(line_mem[p] - 8'd48);
            if (mag > 64'd2147483648) mag = 64'd2147483648;
            p++;
        end
        if (neg) return 32'd0 - mag[31:0];
        return mag > 64'd2147483647 ? 32'h7FFFFFFF : mag[31:0];
    endfunction

    function automatic dec_res_t drive_step(logic [1:0] l, logic [1:0] r, logic [20:0] h);
        dec_res_t d;
        d = '0;
        d.action = tcld_pkg::ACT_DRIVE;
        d.left_drive = l;
        d.right_drive = r;
        d.hold_us = h;
        return d;
    endfunction

    // Decode a finished line; returns the actions it causes
    task automatic decode_line(input int len, output dec_res_t acts [$]);
        int ts [MAX_TOKENS];
        int cnt;
        dec_res_t d;
        logic [7:0] dev;
        logic [7:0] dev_num;
        acts = {};
        if (len == 0) return;
        ts[0] = 0;
        cnt = 1;
        for (int i = 2; i < len; i++)
            if (!is_delim(i) && is_delim(i - 1) && cnt < MAX_TOKENS) begin
                ts[cnt] = i;
                cnt++;
            end
        if (cnt == 1) begin
            if (token_matches(0, len, "START")) begin
                started_q = 1'b1;
                d = '0;
                d.action = tcld_pkg::ACT_START;
                acts.push_back(d);
            end
        end else if (cnt == 2) begin
            if (!token_matches(0, len, "ROBOT")) return;
            if (token_matches(ts[1], len, "FORWARD"))
                acts.push_back(drive_step(tcld_pkg::DRV_FWD, tcld_pkg::DRV_FWD, '0));
            else if (token_matches(ts[1], len, "BACKWARD"))
                acts.push_back(drive_step(tcld_pkg::DRV_REV, tcld_pkg::DRV_REV, '0));
            else if (token_matches(ts[1], len, "RIGHT"))
                acts.push_back(drive_step(tcld_pkg::DRV_FWD, tcld_pkg::DRV_REV, '0));
            else if (token_matches(ts[1], len, "LEFT"))
                acts.push_back(drive_step(tcld_pkg::DRV_REV, tcld_pkg::DRV_FWD, '0));
            else if (token_matches(ts[1], len, "STOP"))
                acts.push_back(drive_step(tcld_pkg::DRV_STOP, tcld_pkg::DRV_STOP, '0));
            else if (token_matches(ts[1], len, "WIGGLE")) begin
                acts.push_back(drive_step(tcld_pkg::DRV_REV, tcld_pkg::DRV_FWD,
                                          tcld_pkg::HOLD_LONG));
                acts.push_back(drive_step(tcld_pkg::DRV_FWD, tcld_pkg::DRV_REV,
                                          tcld_pkg::HOLD_SHORT));
                acts.push_back(drive_step(tcld_pkg::DRV_FWD, tcld_pkg::DRV_FWD,
                                          tcld_pkg::HOLD_LONG));
                acts.push_back(drive_step(tcld_pkg::DRV_STOP, tcld_pkg::DRV_STOP, '0));
            end
        end else if (cnt == 4) begin
            if (token_matches(0, len, "SET") && token_matches(ts[1], len, "OMEGA")) begin
                dev = line_mem[ts[3]];
                if (dev >= "1" && dev <= "3") begin
                    dev_num = dev - 8'd48;
                    d = '0;
                    d.action = tcld_pkg::ACT_OMEGA;
                    d.omega_device = dev_num[1:0];
                    d.omega_value = omega_from_token(ts[2], len);
                    omega_mem[dev_num - 8'd1] = d.omega_value;
                    acts.push_back(d);
                end
            end
        end
    endtask

    // Work out the results of one accepted byte
    task automatic predict_byte(input logic [7:0] b);
        dec_res_t r [$];
        dec_res_t d;
        logic [7:0] c;
        c = b;
        d = '0;
        r = {};
        if ((c >= 8'h20 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            if (c >= 8'h61) c = c - 8'd32;
            if (wr_idx >= LINE_LEN - 2) d.overflow = 1'b1;
            else begin
                line_mem[wr_idx] = c;
                wr_idx++;
                d.echo_kind = tcld_pkg::ECHO_CHAR;
                d.echo_char = c;
            end
        end else if (c == tcld_pkg::CHR_BS) begin
            if (wr_idx > 0) begin
                wr_idx--;
                d.echo_kind = tcld_pkg::ECHO_CHAR;
                d.echo_char = tcld_pkg::CHR_BS;
            end
        end else if (c == tcld_pkg::CHR_CR) begin
            decode_line(wr_idx, r);
            wr_idx = 0;
        end
        if (r.size() == 0) r.push_back(d);
        if (c == tcld_pkg::CHR_CR) r[0].echo_kind = tcld_pkg::ECHO_EOL;
        foreach (r[k]) begin
            r[k].started_flag = started_q;
            r[k].last = (k == r.size() - 1);
            expected_results.push_back(r[k]);
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_byte(s_rx_byte);
                send_gap = gap_len();
            end
            if (s_valid && !s_ready) begin
                // hold the item until taken
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                s_valid <= 1'b1;
                s_rx_byte <= pending_bytes.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor and checker
    int recv_gap = 0;
    always @(posedge aclk) begin
        dec_res_t exp_r;
        cycle_count++;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_overflow) overflows_seen++;
                if (m_action != tcld_pkg::ACT_NONE) actions_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result, echo_kind=%0d", m_echo_kind);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_echo_kind !== exp_r.echo_kind) begin
                        $error("echo_kind exp %0d got %0d", exp_r.echo_kind, m_echo_kind);
                        error_count++;
                    end
                    if (m_echo_char !== exp_r.echo_char) begin
                        $error("echo_char exp %0d got %0d", exp_r.echo_char, m_echo_char);
                        error_count++;
                    end
                    if (m_overflow !== exp_r.overflow) begin
                        $error("overflow exp %0d got %0d", exp_r.overflow, m_overflow);
                        error_count++;
                    end
                    if (m_action !== exp_r.action) begin
                        $error("action exp %0d got %0d", exp_r.action, m_action);
                        error_count++;
                    end
                    if (m_left_drive !== exp_r.left_drive) begin
                        $error("left_drive exp %0d got %0d", exp_r.left_drive, m_left_drive);
                        error_count++;
                    end
                    if (m_right_drive !== exp_r.right_drive) begin
                        $error("right_drive exp %0d got %0d", exp_r.right_drive,
                               m_right_drive);
                        error_count++;
                    end
                    if (m_hold_us !== exp_r.hold_us) begin
                        $error("hold_us exp %0d got %0d", exp_r.hold_us, m_hold_us);
                        error_count++;
                    end
                    if (m_omega_device !== exp_r.omega_device) begin
                        $error("omega_device exp %0d got %0d", exp_r.omega_device,
                               m_omega_device);
                        error_count++;
                    end
                    if (m_omega_value !== exp_r.omega_value) begin
                        $error("omega_value exp %0d got %0d", exp_r.omega_value,
                               m_omega_value);
                        error_count++;
                    end
                    if (m_started_flag !== exp_r.started_flag) begin
                        $error("started_flag exp %0d got %0d", exp_r.started_flag,
                               m_started_flag);
                        error_count++;
                    end
                    if (m_last !== exp_r.last) begin
                        $error("last exp %0d got %0d", exp_r.last, m_last);
                        error_count++;
                    end
                end
            end
            // receiver stalls
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (!stim_done && $urandom_range(0, 5) == 0) begin
                recv_gap = gap_len();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        queued_count++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic queue_line(input string s);
        queue_text(s);
        queue_byte(tcld_pkg::CHR_CR);
    endtask

    // Random printable character in token set or a delimiter
    function automatic logic [7:0] rand_text_char();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return 8'($urandom_range(65, 90) | ($urandom_range(0, 1) << 5));
        if (p < 8) return 8'($urandom_range(48, 57));
        return 8'($urandom_range(32, 64));
    endfunction

    function automatic string rand_command();
        string dirs [6];
        string v;
        string sign;
        int p;
        dirs = '{"FORWARD", "BACKWARD", "RIGHT", "LEFT", "STOP", "WIGGLE"};
        p = $urandom_range(0, 9);
        v = $sformatf("%0d", $urandom_range(0, 99999));
        if ($urandom_range(0, 1)) sign = "-";
        else sign = "";
        if (p == 0) return "start";
        if (p < 5) return {"ROBOT ", dirs[$urandom_range(0, 5)]};
        if (p < 8)
            return {"SET OMEGA ", sign, v, " ", $sformatf("%0d", $urandom_range(0, 4))};
        return {"ROBOT ", dirs[$urandom_range(0, 5)], " X"};
    endfunction

    initial begin
        for (int i = 0; i < LINE_LEN; i++) line_mem[i] = 8'd0;
        wr_idx = 0;
        started_q = 1'b0;
        foreach (omega_mem[i]) omega_mem[i] = 32'd100;

        // directed: empty line, backspace on empty, controls, commands, limits
        queue_byte(tcld_pkg::CHR_CR);
        queue_byte(tcld_pkg::CHR_BS);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h7F);
        queue_line("robot wiggle");
        queue_line("START");
        queue_line("SET OMEGA 99999999999 2");
        queue_line("SET OMEGA -99999999999 3");
        queue_line("SET OMEGA -x 1");
        queue_line("ROBOT LEFT");
        queue_text("ROBOX");
        queue_byte(tcld_pkg::CHR_BS);
        queue_line("T STOP");

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // random: mostly well-formed commands, some noise and full lines
        while (queued_count < ITEM_TARGET) begin
            wait (pending_bytes.size() < 4);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    queue_line(rand_command());
                end
                6: begin
                    repeat (LINE_LEN + 2) queue_byte(rand_text_char());
                    queue_byte(tcld_pkg::CHR_BS);
                    queue_byte(tcld_pkg::CHR_CR);
                end
                7: begin
                    repeat ($urandom_range(1, 5)) queue_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    repeat ($urandom_range(1, 12)) queue_byte(rand_text_char());
                    if ($urandom_range(0, 1)) queue_byte(tcld_pkg::CHR_BS);
                    queue_byte(tcld_pkg::CHR_CR);
                end
            endcase
        end
        wait (pending_bytes.size() == 0 && !s_valid);
        stim_done = 1'b1;
        wait (expected_results.size() == 0);
        repeat (LINE_LEN + 20) @(posedge aclk);
        $display("Sent %0d bytes; checked %0d results: %0d with actions, %0d overflow drops.",
                 queued_count, results_seen, actions_seen, overflows_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
